/* src/stsr_pkg.sv */
// Shared types, constants and helper functions for the scope trace segment renderer.
// Used by the register block, the controller, the datapath and the top level.
package stsr_pkg;

	localparam int COLUMNS     = 256;
	localparam int TRAIL_DEPTH = 8;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_GAIN  = 3'd0;
	localparam logic [2:0] REG_BAND  = 3'd1;
	localparam logic [2:0] REG_FLAT  = 3'd2;
	localparam logic [2:0] REG_FILL  = 3'd3;
	localparam logic [2:0] REG_TRACE = 3'd4;
	localparam logic [2:0] REG_PEAK  = 3'd5;

	localparam logic [9:0]  GAIN_RESET  = 10'd100;
	localparam logic [15:0] TRACE_RESET = 16'h07E0;
	localparam logic [15:0] PEAK_RESET  = 16'hFFE0;

	// Deflection: Q1.15, saturates at full scale
	localparam logic [17:0] SAT_LIMIT     = 18'd12800;
	localparam logic [20:0] ROUND_HALF_50 = 21'd25;
	localparam logic [21:0] REC50_MUL     = 22'd2684354;
	localparam logic [20:0] DIV50         = 21'd50;
	localparam logic [15:0] DEFL_FULL     = 16'h8000;

	// Row geometry (twice the half-height, twice the centre * 2^15)
	localparam logic [5:0]  H2_BAND       = 6'd53;
	localparam logic [5:0]  H2_NORM       = 6'd63;
	localparam logic [22:0] ROW_BASE_BAND = 23'd2424832;
	localparam logic [22:0] ROW_BASE_NORM = 23'd2097152;
	localparam logic [5:0]  CENTRE_BAND   = 6'd37;
	localparam logic [5:0]  CENTRE_NORM   = 6'd32;

	// Colour scaling
	localparam logic [8:0]  BRIGHT_LIVE = 9'd256;
	localparam logic [13:0] W5_MUL      = 14'd8457;
	localparam logic [14:0] W6_MUL      = 15'd16645;
	localparam logic [5:0]  FILL_NUM    = 6'd45;
	localparam logic [14:0] REC100_MUL  = 15'd20972;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_LAST  = CH_BLUE;

	typedef struct packed {
		logic [9:0]  gain;
		logic        band;
		logic        flat;
		logic        fill_on;
		logic [15:0] trace_color;
		logic [15:0] peak_color;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_REC,
		ST_DIV,
		ST_ROW,
		ST_BASE,
		ST_SCALE,
		ST_FSCALE,
		ST_FDIV,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_LOAD,
		STEP_MUL,
		STEP_REC,
		STEP_DIV,
		STEP_ROW,
		STEP_BASE,
		STEP_SCALE,
		STEP_FSCALE,
		STEP_FDIV,
		STEP_OUT
	} step_t;

	typedef struct packed {
		step_t      step;
		logic [1:0] ch;
	} cmd_t;

	// floor(v * 255 / 31)
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [12:0] x;
		logic [26:0] p;
		x = 13'(v) * 13'd255;
		p = 27'(x) * 27'(W5_MUL);
		return p[25:18];
	endfunction

	// floor(v * 255 / 63)
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [13:0] x;
		logic [28:0] p;
		x = 14'(v) * 14'd255;
		p = 29'(x) * 29'(W6_MUL);
		return p[27:20];
	endfunction

	function automatic logic [7:0] chan_of(input logic [15:0] color, input logic [1:0] ch);
		logic [7:0] v;
		case (ch)
			CH_RED:   v = widen5(color[15:11]);
			CH_GREEN: v = widen6(color[10:5]);
			default:  v = widen5(color[4:0]);
		endcase
		return v;
	endfunction

	// Q1.8 brightness: live is 1.0, trail ages fall by 0.10 from 0.38
	function automatic logic [8:0] bright_of(input logic live, input logic [2:0] age);
		logic [8:0] b;
		if (live) begin
			b = BRIGHT_LIVE;
		end else if (int'(age) >= TRAIL_DEPTH) begin
			b = 9'd0;
		end else begin
			case (age)
				3'd0:    b = 9'd97;
				3'd1:    b = 9'd72;
				3'd2:    b = 9'd46;
				3'd3:    b = 9'd20;
				default: b = 9'd0;
			endcase
		end
		return b;
	endfunction

endpackage

/* src/stsr_cfg.sv */
// Configuration registers behind the APB-style port.
// Depends on stsr_pkg for register indexes, reset values and cfg_t.
module stsr_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output stsr_pkg::cfg_t   cfg
);
	import stsr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain        <= GAIN_RESET;
			cfg_q.band        <= 1'b0;
			cfg_q.flat        <= 1'b0;
			cfg_q.fill_on     <= 1'b0;
			cfg_q.trace_color <= TRACE_RESET;
			cfg_q.peak_color  <= PEAK_RESET;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_GAIN:  cfg_q.gain        <= pwdata[9:0];
				REG_BAND:  cfg_q.band        <= pwdata[0];
				REG_FLAT:  cfg_q.flat        <= pwdata[0];
				REG_FILL:  cfg_q.fill_on     <= pwdata[0];
				REG_TRACE: cfg_q.trace_color <= pwdata[15:0];
				REG_PEAK:  cfg_q.peak_color  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GAIN:  prdata = 32'(cfg_q.gain);
			REG_BAND:  prdata = 32'(cfg_q.band);
			REG_FLAT:  prdata = 32'(cfg_q.flat);
			REG_FILL:  prdata = 32'(cfg_q.fill_on);
			REG_TRACE: prdata = 32'(cfg_q.trace_color);
			REG_PEAK:  prdata = 32'(cfg_q.peak_color);
			default:   prdata = 32'd0;
		endcase
	end

endmodule

/* src/stsr_ctrl.sv */
// Controller: steps one item through the datapath and manages the output register handshake.
// Depends on stsr_pkg for state_t, step_t and cmd_t.
module stsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output stsr_pkg::cmd_t cmd
);
	import stsr_pkg::*;

	state_t     state_q, state_nx;
	logic [1:0] ch_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_MUL;
			ST_MUL:    state_nx = ST_REC;
			ST_REC:    state_nx = ST_DIV;
			ST_DIV:    state_nx = ST_ROW;
			ST_ROW:    state_nx = ST_BASE;
			ST_BASE:   state_nx = ST_SCALE;
			ST_SCALE:  state_nx = ST_FSCALE;
			ST_FSCALE: state_nx = ST_FDIV;
			ST_FDIV:   state_nx = (ch_q == CH_LAST) ? ST_DONE : ST_BASE;
			ST_DONE:   if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.step = STEP_NONE;
		cmd.ch   = ch_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.step = STEP_LOAD;
			end
			ST_MUL:    cmd.step = STEP_MUL;
			ST_REC:    cmd.step = STEP_REC;
			ST_DIV:    cmd.step = STEP_DIV;
			ST_ROW:    cmd.step = STEP_ROW;
			ST_BASE:   cmd.step = STEP_BASE;
			ST_SCALE:  cmd.step = STEP_SCALE;
			ST_FSCALE: cmd.step = STEP_FSCALE;
			ST_FDIV:   cmd.step = STEP_FDIV;
			ST_DONE:   if (out_free) cmd.step = STEP_OUT;
			default:   cmd.step = STEP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= CH_RED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) begin
				ch_q <= CH_RED;
			end else if (state_q == ST_FDIV) begin
				ch_q <= ch_q + 2'd1;
			end
			if (cmd.step == STEP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/stsr_dpath.sv */
// Datapath: deflection, row, per-channel colour scaling and the output register.
// Depends on stsr_pkg for cmd_t, cfg_t, constants and the colour helper functions.
module stsr_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  stsr_pkg::cmd_t cmd,
	input  stsr_pkg::cfg_t cfg,
	input  logic [7:0]     sample,
	input  logic [7:0]     column,
	input  logic           live_trace,
	input  logic [2:0]     trail_age,
	output logic [7:0]     x_pos,
	output logic [5:0]     row,
	output logic [5:0]     prev_row,
	output logic           is_segment,
	output logic [15:0]    line_color,
	output logic           fill_enable,
	output logic [15:0]    fill_color,
	output logic [5:0]     centre_row
);
	import stsr_pkg::*;

	logic [7:0]  sample_q, column_q;
	logic        live_q;
	logic [2:0]  age_q;
	logic [17:0] mag_q;
	logic        neg_q, sat_q;
	logic [20:0] a_q;
	logic [15:0] qest_q, dmag_q, hot_q;
	logic [8:0]  bright_q;
	logic [5:0]  row_q, prev_q, last_row_q;
	logic        seg_q;
	logic [22:0] base_q;
	logic [30:0] lprod_q;
	logic [13:0] fx_q;
	logic [7:0]  line_ch_q [3];
	logic [7:0]  fill_ch_q [3];

	logic [7:0]  out_x_q;
	logic [5:0]  out_row_q, out_prev_q, out_centre_q;
	logic        out_seg_q, out_fill_en_q;
	logic [15:0] out_line_q, out_fill_q;

	logic [7:0]         absoff_w;
	logic [17:0]        mag_w;
	logic [20:0]        a_w;
	logic [42:0]        recp_w;
	logic [20:0]        rem_w;
	logic [15:0]        qc_w;
	logic [5:0]         h2_w;
	logic [22:0]        hp_w, rbase_w, rnum_w;
	logic [5:0]         row_w;
	logic               seg_w;
	logic [7:0]         t_w, p_w;
	logic signed [25:0] diff_w, hotx_w, mul_w, base_w;
	logic [31:0]        sprod_w;
	logic [36:0]        f45_w;
	logic [28:0]        fd_w;
	logic [15:0]        line_pack_w, fill_pack_w;

	always_comb begin
		absoff_w = sample_q[7] ? {1'b0, sample_q[6:0]} : 8'(9'd128 - {1'b0, sample_q});
		mag_w    = 18'(absoff_w) * 18'(cfg.gain);
		a_w      = {mag_q[13:0], 7'b0} + ROUND_HALF_50;
		recp_w   = 43'(a_w) * 43'(REC50_MUL);
		rem_w    = a_q - 21'(qest_q) * DIV50;
		qc_w     = (rem_w >= DIV50) ? qest_q + 16'd1 : qest_q;
		h2_w     = cfg.band ? H2_BAND : H2_NORM;
		hp_w     = 23'(dmag_q) * 23'(h2_w);
		rbase_w  = cfg.band ? ROW_BASE_BAND : ROW_BASE_NORM;
		rnum_w   = neg_q ? rbase_w + hp_w : rbase_w - hp_w;
		row_w    = rnum_w[21:16];
		seg_w    = (column_q != 8'd0) && (int'(column_q) < COLUMNS);
		t_w      = chan_of(cfg.trace_color, cmd.ch);
		p_w      = chan_of(cfg.peak_color, cmd.ch);
		diff_w   = $signed(26'(p_w)) - $signed(26'(t_w));
		hotx_w   = $signed(26'(hot_q));
		mul_w    = diff_w * hotx_w;
		base_w   = $signed({3'b0, t_w, 15'b0}) + mul_w;
		sprod_w  = 32'(base_q) * 32'(bright_q);
		f45_w    = 37'(lprod_q) * 37'(FILL_NUM);
		fd_w     = 29'(fx_q) * 29'(REC100_MUL);
		line_pack_w = {line_ch_q[CH_RED][7:3], line_ch_q[CH_GREEN][7:2], line_ch_q[CH_BLUE][7:3]};
		fill_pack_w = {fill_ch_q[CH_RED][7:3], fill_ch_q[CH_GREEN][7:2], fill_ch_q[CH_BLUE][7:3]};
	end

	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_LOAD: begin
				sample_q <= sample;
				column_q <= column;
				live_q   <= live_trace;
				age_q    <= trail_age;
			end
			STEP_MUL: begin
				mag_q <= mag_w;
				neg_q <= ~sample_q[7];
			end
			STEP_REC: begin
				sat_q  <= (mag_q >= SAT_LIMIT);
				a_q    <= a_w;
				qest_q <= recp_w[42:27];
			end
			STEP_DIV: begin
				dmag_q <= sat_q ? DEFL_FULL : qc_w;
			end
			STEP_ROW: begin
				row_q    <= row_w;
				prev_q   <= seg_w ? last_row_q : row_w;
				seg_q    <= seg_w;
				hot_q    <= cfg.flat ? 16'd0 : dmag_q;
				bright_q <= bright_of(live_q, age_q);
			end
			STEP_BASE: begin
				base_q <= base_w[22:0];
			end
			STEP_SCALE: begin
				lprod_q <= sprod_w[30:0];
			end
			STEP_FSCALE: begin
				line_ch_q[cmd.ch] <= lprod_q[30:23];
				fx_q              <= f45_w[36:23];
			end
			STEP_FDIV: begin
				fill_ch_q[cmd.ch] <= fd_w[28:21];
			end
			STEP_OUT: begin
				out_x_q       <= column_q;
				out_row_q     <= row_q;
				out_prev_q    <= prev_q;
				out_seg_q     <= seg_q;
				out_line_q    <= line_pack_w;
				out_fill_en_q <= cfg.fill_on;
				out_fill_q    <= cfg.fill_on ? fill_pack_w : 16'd0;
				out_centre_q  <= cfg.band ? CENTRE_BAND : CENTRE_NORM;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= 6'd0;
		end else if (cmd.step == STEP_ROW) begin
			last_row_q <= row_w;
		end
	end

	assign x_pos       = out_x_q;
	assign row         = out_row_q;
	assign prev_row    = out_prev_q;
	assign is_segment  = out_seg_q;
	assign line_color  = out_line_q;
	assign fill_enable = out_fill_en_q;
	assign fill_color  = out_fill_q;
	assign centre_row  = out_centre_q;

endmodule

/* src/scope_trace_segment_render.sv */
// Scope trace segment renderer: one screen point per waveform sample, with line segment data.
// An item is taken only while the controller is idle; its result is registered after the last colour step,
// once the output register is free. Items do not overlap: each runs the shared multiply steps (four for
// deflection and row, four per colour channel); an unstalled output register lets the next item in at once.
// Reset: registers return to their documented values, the last row clears to 0, no item pending.
module scope_trace_segment_render (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sample,
	input  logic [7:0]  column,
	input  logic        live_trace,
	input  logic [2:0]  trail_age,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  x_pos,
	output logic [5:0]  row,
	output logic [5:0]  prev_row,
	output logic        is_segment,
	output logic [15:0] line_color,
	output logic        fill_enable,
	output logic [15:0] fill_color,
	output logic [5:0]  centre_row
);
	import stsr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	assign pready = 1'b1;

	stsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	stsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	stsr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.sample      (sample),
		.column      (column),
		.live_trace  (live_trace),
		.trail_age   (trail_age),
		.x_pos       (x_pos),
		.row         (row),
		.prev_row    (prev_row),
		.is_segment  (is_segment),
		.line_color  (line_color),
		.fill_enable (fill_enable),
		.fill_color  (fill_color),
		.centre_row  (centre_row)
	);

endmodule

/* bench/scope_trace_segment_render_tb.sv */
// Self-checking bench for scope_trace_segment_render: drives samples and APB register
// writes, predicts every rendered point and compares it field by field on the output side.
// Depends on stsr_pkg for register indexes, channel codes and the configuration struct.
`timescale 1ns / 1ps

module scope_trace_segment_render_tb;
	import stsr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 24;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 121;

	typedef struct {
		logic [7:0] smp;
		logic [7:0] col;
		logic       live;
		logic [2:0] age;
	} scope_sample_t;

	typedef struct {
		logic [7:0]  x_pos;
		logic [5:0]  row;
		logic [5:0]  prev_row;
		logic        seg;
		logic [15:0] line_color;
		logic        fill_en;
		logic [15:0] fill_color;
		logic [5:0]  centre;
	} trace_point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  sample = '0;
	logic [7:0]  column = '0;
	logic        live_trace = 1'b0;
	logic [2:0]  trail_age = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  x_pos;
	logic [5:0]  row;
	logic [5:0]  prev_row;
	logic        is_segment;
	logic [15:0] line_color;
	logic        fill_enable;
	logic [15:0] fill_color;
	logic [5:0]  centre_row;

	scope_sample_t samples_to_send[$];
	trace_point_t  points_due[$];
	cfg_t          regs_shadow;
	logic [5:0]    trace_last_row = '0;
	int            mismatches = 0;
	int            clk_cycles = 0;
	int            send_gap = 0;
	int            recv_hold = 0;
	bit            send_calm = 1'b0;
	bit            recv_calm = 1'b0;
	logic [7:0]    next_col = '0;

	scope_trace_segment_render DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .column(column), .live_trace(live_trace), .trail_age(trail_age),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_pos(x_pos), .row(row), .prev_row(prev_row), .is_segment(is_segment),
		.line_color(line_color), .fill_enable(fill_enable), .fill_color(fill_color),
		.centre_row(centre_row)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint widen_chan(logic [15:0] color, int ch);
		longint v;
		case (ch)
			CH_RED:   v = longint'(color[15:11]) * 255 / 31;
			CH_GREEN: v = longint'(color[10:5]) * 255 / 63;
			default:  v = longint'(color[4:0]) * 255 / 31;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] sat8(longint v);
		return (v > 255) ? 8'd255 : ((v < 0) ? 8'd0 : v[7:0]);
	endfunction

	function automatic logic [15:0] pack_rgb565(longint r, longint g, longint b);
		logic [7:0] ur;
		logic [7:0] ug;
		logic [7:0] ub;
		ur = sat8(r);
		ug = sat8(g);
		ub = sat8(b);
		return {ur[7:3], ug[7:2], ub[7:3]};
	endfunction

	function automatic trace_point_t render_point(scope_sample_t s, cfg_t c, logic [5:0] last);
		longint       num;
		longint       defl;
		longint       c2;
		longint       h2;
		longint       hot;
		longint       bright;
		longint       t;
		longint       base;
		longint       prod;
		longint       lc[3];
		longint       fc[3];
		trace_point_t p;
		num = (longint'(s.smp) - 128) * longint'(c.gain);
		if (num >= 12800)
			defl = 32768;
		else if (num <= -12800)
			defl = -32768;
		else if (num >= 0)
			defl = (num * 128 + 25) / 50;
		else
			defl = -((-num * 128 + 25) / 50);
		c2 = c.band ? 73 : 63;
		h2 = c.band ? 53 : 63;
		p.row = 6'((c2 * 32768 - defl * h2 + 32768) / 65536);
		p.centre = c.band ? 6'd37 : 6'd32;
		hot = c.flat ? 0 : ((defl < 0) ? -defl : defl);
		if (s.live) begin
			bright = 256;
		end else if (int'(s.age) >= TRAIL_DEPTH) begin
			bright = 0;
		end else begin
			t = (38 - 10 * longint'(s.age)) * 256;
			bright = (t >= 0) ? (t + 50) / 100 : 0;
		end
		for (int ch = 0; ch < 3; ch++) begin
			base = widen_chan(c.trace_color, ch) * 32768
				+ (widen_chan(c.peak_color, ch) - widen_chan(c.trace_color, ch)) * hot;
			prod = base * bright;
			lc[ch] = prod / 8388608;
			fc[ch] = (prod * 45) / 838860800;
		end
		p.line_color = pack_rgb565(lc[CH_RED], lc[CH_GREEN], lc[CH_BLUE]);
		p.fill_color = c.fill_on ? pack_rgb565(fc[CH_RED], fc[CH_GREEN], fc[CH_BLUE]) : 16'd0;
		p.fill_en = c.fill_on;
		p.seg = (s.col != 0) && (int'(s.col) < COLUMNS);
		p.prev_row = p.seg ? last : p.row;
		p.x_pos = s.col;
		return p;
	endfunction

	// sender: hold while stalled, otherwise idle out the drawn gap or present the next item
	always @(posedge clk or negedge arst_n) begin
		scope_sample_t cur;
		scope_sample_t nxt;
		trace_point_t  p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			column <= '0;
			live_trace <= 1'b0;
			trail_age <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				cur.smp = sample;
				cur.col = column;
				cur.live = live_trace;
				cur.age = trail_age;
				p = render_point(cur, regs_shadow, trace_last_row);
				points_due.push_back(p);
				trace_last_row = p.row;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() != 0) begin
					nxt = samples_to_send.pop_front();
					sample <= nxt.smp;
					column <= nxt.col;
					live_trace <= nxt.live;
					trail_age <= nxt.age;
					in_valid <= 1'b1;
					if ($urandom_range(0, 99) < 4)
						send_calm = !send_calm;
					send_gap <= send_calm ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// receiver: compare each accepted point, then stall the next one for a drawn count
	always @(posedge clk or negedge arst_n) begin
		trace_point_t want;
		int           n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					$error("point at column %0d with none expected", x_pos);
					mismatches++;
				end else begin
					want = points_due.pop_front();
					check_field("x_pos", 16'(want.x_pos), 16'(x_pos));
					check_field("row", 16'(want.row), 16'(row));
					check_field("prev_row", 16'(want.prev_row), 16'(prev_row));
					check_field("is_segment", 16'(want.seg), 16'(is_segment));
					check_field("line_color", want.line_color, line_color);
					check_field("fill_enable", 16'(want.fill_en), 16'(fill_enable));
					check_field("fill_color", want.fill_color, fill_color);
					check_field("centre_row", 16'(want.centre), 16'(centre_row));
				end
				if ($urandom_range(0, 99) < 4)
					recv_calm = !recv_calm;
				n = recv_calm ? 0 : $urandom_range(0, 5);
			end else if (out_valid && recv_hold > 0) begin
				n = recv_hold - 1;
			end else begin
				n = recv_hold;
			end
			recv_hold <= n;
			out_stall <= (n != 0);
		end
	end

	always @(posedge clk) begin
		clk_cycles <= clk_cycles + 1;
		if (clk_cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN:  regs_shadow.gain = val[9:0];
			REG_BAND:  regs_shadow.band = val[0];
			REG_FLAT:  regs_shadow.flat = val[0];
			REG_FILL:  regs_shadow.fill_on = val[0];
			REG_TRACE: regs_shadow.trace_color = val[15:0];
			REG_PEAK:  regs_shadow.peak_color = val[15:0];
			default: ;
		endcase
	endtask

	task automatic push_sample(int smp, int col, bit live, int age);
		scope_sample_t s;
		s.smp = smp[7:0];
		s.col = col[7:0];
		s.live = live;
		s.age = age[2:0];
		samples_to_send.push_back(s);
	endtask

	task automatic push_random(int count);
		int smp;
		int col;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2: col = $urandom_range(0, 255);
				3: begin
					col = 0;
					next_col = 8'd1;
				end
				default: begin
					col = int'(next_col);
					next_col = next_col + 8'd1;
				end
			endcase
			case ($urandom_range(0, 19))
				0, 1, 2: smp = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1)
					: $urandom_range(254, 255);
				3, 4, 5, 6, 7, 8, 9: smp = 108 + $urandom_range(0, 40);
				default: smp = $urandom_range(0, 255);
			endcase
			push_sample(smp, col, 1'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
		end
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1023;
			2: return 32'd1000;
			3: return 32'd100;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 5))
			0: return 32'h0000;
			1: return 32'hFFFF;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic wait_idle();
		while (samples_to_send.size() != 0 || points_due.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		regs_shadow.gain = GAIN_RESET;
		regs_shadow.band = 1'b0;
		regs_shadow.flat = 1'b0;
		regs_shadow.fill_on = 1'b0;
		regs_shadow.trace_color = TRACE_RESET;
		regs_shadow.peak_color = PEAK_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers; first point continues from the cleared last row
		push_sample(128, 5, 1'b1, 0);
		push_sample(0, 0, 1'b1, 0);
		push_sample(255, 1, 1'b1, 0);
		push_sample(128, 2, 1'b1, 0);
		push_sample(127, 3, 1'b0, 0);
		push_sample(129, 4, 1'b0, 1);
		push_sample(1, 5, 1'b0, 2);
		push_sample(254, 6, 1'b0, 3);
		push_sample(64, 7, 1'b0, 4);
		push_sample(192, 8, 1'b0, 5);
		push_sample(100, 9, 1'b0, 6);
		push_sample(200, 10, 1'b0, 7);
		push_sample(0, 255, 1'b1, 0);
		push_sample(255, 254, 1'b0, 0);
		push_sample(128, 0, 1'b0, 7);
		push_sample(140, 128, 1'b1, 3);
		wait_idle();

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_GAIN, 32'd1000);
					write_reg(REG_BAND, 32'd1);
					write_reg(REG_FLAT, 32'd0);
					write_reg(REG_FILL, 32'd1);
					write_reg(REG_TRACE, 32'h0000);
					write_reg(REG_PEAK, 32'hFFFF);
				end
				2: begin
					write_reg(REG_GAIN, 32'd0);
					write_reg(REG_BAND, 32'd0);
					write_reg(REG_FLAT, 32'd1);
					write_reg(REG_FILL, 32'd1);
					write_reg(REG_TRACE, 32'hFFFF);
					write_reg(REG_PEAK, 32'h0000);
				end
				3: begin
					write_reg(REG_GAIN, 32'd1023);
					write_reg(REG_BAND, 32'd1);
					write_reg(REG_FLAT, 32'd1);
					write_reg(REG_FILL, 32'd0);
					write_reg(REG_TRACE, pick_color());
					write_reg(REG_PEAK, pick_color());
				end
				default: begin
					write_reg(REG_GAIN, pick_gain());
					write_reg(REG_BAND, $urandom_range(0, 1));
					write_reg(REG_FLAT, $urandom_range(0, 1));
					write_reg(REG_FILL, $urandom_range(0, 1));
					write_reg(REG_TRACE, pick_color());
					write_reg(REG_PEAK, pick_color());
				end
			endcase
			@(negedge clk);
			if (ph == 1) begin
				push_sample(140, 1, 1'b1, 0);
				push_sample(141, 2, 1'b1, 0);
				push_sample(116, 3, 1'b1, 0);
				push_sample(115, 4, 1'b0, 0);
			end
			push_random(PHASE_ITEMS);
			wait_idle();
		end

		if (points_due.size() != 0) begin
			$error("%0d points never arrived", points_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
